### src/ecdc_pkg.sv
package ecdc_pkg;

   // Build-time defaults
   localparam int FLOORS_DEFAULT     = 8;
   localparam int HOME_FLOOR_DEFAULT = 2;

   // Field widths
   localparam int OP_WIDTH    = 3;
   localparam int FLOOR_WIDTH = 3;
   localparam int POS_WIDTH   = 15;
   localparam int DOOR_WIDTH  = 2;
   localparam int DPOS_WIDTH  = 10;
   localparam int REQ_WIDTH   = 8;
   localparam int SPF_WIDTH   = 12;
   localparam int HOLD_WIDTH  = 16;

   // CSR port
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [1:0] REG_STEPS_PER_FLOOR = 2'd0;
   localparam logic [1:0] REG_DOOR_TRAVEL     = 2'd1;
   localparam logic [1:0] REG_DOOR_HOLD       = 2'd2;

   localparam logic [SPF_WIDTH-1:0]  SPF_RESET    = 12'd23;
   localparam logic [DPOS_WIDTH-1:0] TRAVEL_RESET = 10'd75;
   localparam logic [HOLD_WIDTH-1:0] HOLD_RESET   = 16'd375;

   // Item op codes
   localparam logic [OP_WIDTH-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_REQUEST = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_OPEN    = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_CLOSE   = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_STOP    = 3'd4;

   // Door state codes
   localparam logic [DOOR_WIDTH-1:0] DS_CLOSED  = 2'd0;
   localparam logic [DOOR_WIDTH-1:0] DS_OPENING = 2'd1;
   localparam logic [DOOR_WIDTH-1:0] DS_OPEN    = 2'd2;
   localparam logic [DOOR_WIDTH-1:0] DS_CLOSING = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]    op;
      logic [FLOOR_WIDTH-1:0] floor;
   } req_payload_type;

   typedef struct packed {
      logic [FLOOR_WIDTH-1:0] current_floor;
      logic [FLOOR_WIDTH-1:0] target_floor;
      logic [POS_WIDTH-1:0]   car_position;
      logic [DOOR_WIDTH-1:0]  door_state;
      logic [DPOS_WIDTH-1:0]  door_position;
      logic [REQ_WIDTH-1:0]   requests;
      logic                   stopped;
   } rsp_payload_type;

   typedef struct packed {
      logic [SPF_WIDTH-1:0]  steps_per_floor;
      logic [DPOS_WIDTH-1:0] door_travel_ticks;
      logic [HOLD_WIDTH-1:0] door_hold_ticks;
   } cfg_type;

   // Shaft position of a floor: 3 x 12 bit product, fits 15 bits exactly
   function automatic logic [POS_WIDTH-1:0] floor_pos(
      input logic [FLOOR_WIDTH-1:0] f,
      input logic [SPF_WIDTH-1:0]   spf
   );
      return POS_WIDTH'(f) * POS_WIDTH'(spf);
   endfunction

   // Lowest pending request, else the fallback floor
   function automatic logic [FLOOR_WIDTH-1:0] lowest_request(
      input logic [REQ_WIDTH-1:0]   bits,
      input logic [FLOOR_WIDTH-1:0] fallback
   );
      logic [FLOOR_WIDTH-1:0] pick;
      pick = fallback;
      for (int i = REQ_WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pick = FLOOR_WIDTH'(i);
         end
      end
      return pick;
   endfunction

endpackage

### src/ecdc_stream_if.sv
interface ecdc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/ecdc_csr.sv
module ecdc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ecdc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ecdc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ecdc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output ecdc_pkg::cfg_type                    cfg
);

   logic [ecdc_pkg::SPF_WIDTH-1:0]  spf_ff;
   logic [ecdc_pkg::DPOS_WIDTH-1:0] travel_ff;
   logic [ecdc_pkg::HOLD_WIDTH-1:0] hold_ff;
   logic                            wr_en;
   logic [1:0]                      reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         spf_ff    <= ecdc_pkg::SPF_RESET;
         travel_ff <= ecdc_pkg::TRAVEL_RESET;
         hold_ff   <= ecdc_pkg::HOLD_RESET;
      end else if (wr_en) begin
         case (reg_index)
            ecdc_pkg::REG_STEPS_PER_FLOOR: begin
               spf_ff <= csr_pwdata[ecdc_pkg::SPF_WIDTH-1:0];
            end
            ecdc_pkg::REG_DOOR_TRAVEL: begin
               travel_ff <= csr_pwdata[ecdc_pkg::DPOS_WIDTH-1:0];
            end
            ecdc_pkg::REG_DOOR_HOLD: begin
               hold_ff <= csr_pwdata[ecdc_pkg::HOLD_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ecdc_pkg::REG_STEPS_PER_FLOOR: csr_prdata = ecdc_pkg::CSR_DATA_WIDTH'(spf_ff);
         ecdc_pkg::REG_DOOR_TRAVEL:     csr_prdata = ecdc_pkg::CSR_DATA_WIDTH'(travel_ff);
         ecdc_pkg::REG_DOOR_HOLD:       csr_prdata = ecdc_pkg::CSR_DATA_WIDTH'(hold_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   assign cfg.steps_per_floor   = spf_ff;
   assign cfg.door_travel_ticks = travel_ff;
   assign cfg.door_hold_ticks   = hold_ff;

endmodule

### src/elevator_car_door_controller.sv
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    op[2:0], floor[2:0]
// rsp_chan  out  valid/ready    current_floor, target_floor, car_position,
//                               door_state, door_position, requests, stopped
// csr_*     in   APB write/read steps_per_floor @0, door_travel_ticks @4,
//                               door_hold_ticks @8
//
// One item per cycle while rsp_chan is not stalled; an item passes the input
// register, then the state update writes the result register, which raises
// rsp valid.
// Every item yields exactly one result, the state after that item.
// Synchronous active-high reset: car at HOME_FLOOR level, doors closed,
// no requests, stop off; CSRs return to their reset values.
// A stalled rsp_chan holds the result register; the input register still
// takes one more item, and req_chan.ready drops only when both are full.
module elevator_car_door_controller #(
   parameter int FLOORS     = ecdc_pkg::FLOORS_DEFAULT,
   parameter int HOME_FLOOR = ecdc_pkg::HOME_FLOOR_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ecdc_stream_if.sink                          req_chan,
   ecdc_stream_if.source                        rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ecdc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ecdc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ecdc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int FW = ecdc_pkg::FLOOR_WIDTH;
   localparam int PW = ecdc_pkg::POS_WIDTH;
   localparam int DW = ecdc_pkg::DPOS_WIDTH;
   localparam int HW = ecdc_pkg::HOLD_WIDTH;
   localparam int RW = ecdc_pkg::REQ_WIDTH;

   // Valid floors; bits at or above FLOORS are never set
   localparam logic [RW-1:0] FLOOR_MASK = RW'((1 << FLOORS) - 1);
   localparam logic [FW-1:0] HOME_IDX   = FW'(HOME_FLOOR);
   // Reset position uses the reset value of steps_per_floor
   localparam logic [PW-1:0] HOME_POS   = PW'(HOME_FLOOR) * PW'(ecdc_pkg::SPF_RESET);

   ecdc_pkg::cfg_type cfg;

   ecdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- handshake / pipeline control ----------------
   logic                             s1_valid_ff;
   ecdc_pkg::req_payload_type        s1_item_ff;
   logic                             rsp_valid_ff;
   ecdc_pkg::rsp_payload_type        rsp_data_ff;
   logic                             advance;
   logic                             update;

   // Result register free or draining this cycle
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign update         = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   // ---------------- controller state ----------------
   logic [PW-1:0]                  car_pos_ff,   car_pos_in;
   logic [FW-1:0]                  cur_floor_ff, cur_floor_in;
   logic [ecdc_pkg::DOOR_WIDTH-1:0] door_fsm_ff, door_fsm_in;
   logic [DW-1:0]                  door_pos_ff,  door_pos_in;
   logic [HW-1:0]                  hold_ff,      hold_in;
   logic [RW-1:0]                  req_bits_ff,  req_bits_in;
   logic                           arrived_ff,   arrived_in;
   logic                           stop_ff,      stop_in;

   // next-state intermediates
   logic [FW-1:0]  tgt;
   logic [PW-1:0]  tgt_pos;
   logic [PW-1:0]  cur_pos;
   logic           level;
   logic [DW:0]    door_sum;
   logic [HW:0]    hold_sum;
   logic           floor_ok;

   always_comb begin
      car_pos_in   = car_pos_ff;
      cur_floor_in = cur_floor_ff;
      door_fsm_in  = door_fsm_ff;
      door_pos_in  = door_pos_ff;
      hold_in      = hold_ff;
      req_bits_in  = req_bits_ff;
      arrived_in   = arrived_ff;
      stop_in      = stop_ff;

      tgt      = ecdc_pkg::lowest_request(req_bits_ff, cur_floor_ff);
      tgt_pos  = ecdc_pkg::floor_pos(tgt, cfg.steps_per_floor);
      cur_pos  = ecdc_pkg::floor_pos(cur_floor_ff, cfg.steps_per_floor);
      level    = (car_pos_ff == cur_pos);
      door_sum = {1'b0, door_pos_ff} + (DW+1)'(1);
      hold_sum = {1'b0, hold_ff} + {1'b0, cfg.door_hold_ticks};
      floor_ok = ({1'b0, s1_item_ff.floor} < (FW+1)'(FLOORS));

      case (s1_item_ff.op)
         ecdc_pkg::OP_TICK: begin
            if (!stop_ff) begin
               // car step and arrival, only with doors closed
               if (door_fsm_in == ecdc_pkg::DS_CLOSED) begin
                  if (car_pos_ff < tgt_pos) begin
                     car_pos_in = car_pos_ff + PW'(1);
                  end else if (car_pos_ff > tgt_pos) begin
                     car_pos_in = car_pos_ff - PW'(1);
                  end
                  if (car_pos_in == tgt_pos) begin
                     if (!arrived_ff) begin
                        cur_floor_in = tgt;
                        req_bits_in  = req_bits_ff & ~(RW'(1) << tgt);
                        door_fsm_in  = ecdc_pkg::DS_OPENING;
                        arrived_in   = 1'b1;
                     end
                  end else begin
                     arrived_in = 1'b0;
                  end
               end
               // door phases fall through within the same tick
               if (door_fsm_in == ecdc_pkg::DS_OPENING) begin
                  if (door_sum >= {1'b0, cfg.door_travel_ticks}) begin
                     door_pos_in = cfg.door_travel_ticks;
                     door_fsm_in = ecdc_pkg::DS_OPEN;
                     hold_in     = cfg.door_hold_ticks;
                  end else begin
                     door_pos_in = door_sum[DW-1:0];
                  end
               end
               if (door_fsm_in == ecdc_pkg::DS_OPEN) begin
                  if (hold_in <= HW'(1)) begin
                     hold_in     = '0;
                     door_fsm_in = ecdc_pkg::DS_CLOSING;
                  end else begin
                     hold_in = hold_in - HW'(1);
                  end
               end
               if (door_fsm_in == ecdc_pkg::DS_CLOSING) begin
                  if (door_pos_in <= DW'(1)) begin
                     door_pos_in = '0;
                     door_fsm_in = ecdc_pkg::DS_CLOSED;
                  end else begin
                     door_pos_in = door_pos_in - DW'(1);
                  end
               end
            end
         end
         ecdc_pkg::OP_REQUEST: begin
            if (floor_ok) begin
               if (s1_item_ff.floor == cur_floor_ff && level) begin
                  // already level here: reopen instead of queuing
                  if (door_fsm_ff == ecdc_pkg::DS_CLOSED) begin
                     door_fsm_in = ecdc_pkg::DS_OPENING;
                     arrived_in  = 1'b1;
                  end
                  req_bits_in = req_bits_ff & ~(RW'(1) << s1_item_ff.floor);
               end else begin
                  req_bits_in = (req_bits_ff | (RW'(1) << s1_item_ff.floor)) & FLOOR_MASK;
               end
            end
         end
         ecdc_pkg::OP_OPEN: begin
            if (door_fsm_ff == ecdc_pkg::DS_OPEN) begin
               hold_in = hold_sum[HW] ? {HW{1'b1}} : hold_sum[HW-1:0];
            end else if (door_fsm_ff == ecdc_pkg::DS_CLOSED && level) begin
               door_fsm_in = ecdc_pkg::DS_OPENING;
               arrived_in  = 1'b1;
            end
         end
         ecdc_pkg::OP_CLOSE: begin
            if (door_fsm_ff == ecdc_pkg::DS_OPEN ||
                door_fsm_ff == ecdc_pkg::DS_OPENING) begin
               door_fsm_in = ecdc_pkg::DS_CLOSING;
            end
         end
         ecdc_pkg::OP_STOP: begin
            stop_in = !stop_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         car_pos_ff   <= HOME_POS;
         cur_floor_ff <= HOME_IDX;
         door_fsm_ff  <= ecdc_pkg::DS_CLOSED;
         door_pos_ff  <= '0;
         hold_ff      <= '0;
         req_bits_ff  <= '0;
         arrived_ff   <= 1'b0;
         stop_ff      <= 1'b0;
      end else if (update) begin
         car_pos_ff   <= car_pos_in;
         cur_floor_ff <= cur_floor_in;
         door_fsm_ff  <= door_fsm_in;
         door_pos_ff  <= door_pos_in;
         hold_ff      <= hold_in;
         req_bits_ff  <= req_bits_in;
         arrived_ff   <= arrived_in;
         stop_ff      <= stop_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_data_ff.current_floor <= cur_floor_in;
         rsp_data_ff.target_floor  <= ecdc_pkg::lowest_request(req_bits_in, cur_floor_in);
         rsp_data_ff.car_position  <= car_pos_in;
         rsp_data_ff.door_state    <= door_fsm_in;
         rsp_data_ff.door_position <= door_pos_in;
         rsp_data_ff.requests      <= req_bits_in;
         rsp_data_ff.stopped       <= stop_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------- assertions ----------------
   a_closed_means_shut: assert property (@(posedge clock) disable iff (reset)
      door_fsm_ff == ecdc_pkg::DS_CLOSED |-> door_pos_ff == '0)
      else $error("door closed with nonzero door position");

   a_requests_in_range: assert property (@(posedge clock) disable iff (reset)
      (req_bits_ff & ~FLOOR_MASK) == '0)
      else $error("request bit set for a floor outside the shaft");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (car_pos_ff == $past(car_pos_ff) ||
                         car_pos_ff == $past(car_pos_ff) + PW'(1) ||
                         car_pos_ff == $past(car_pos_ff) - PW'(1)))
      else $error("car moved more than one step");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !update |=> ($stable(door_fsm_ff) && $stable(req_bits_ff) && $stable(stop_ff)))
      else $error("state changed without an item update");

endmodule

### test/ecdc_tb_pkg.sv
`timescale 1ns / 100ps
package ecdc_tb_pkg;
   import ecdc_pkg::*;

   // Op codes the block must ignore
   localparam logic [OP_WIDTH-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_LAST  = 3'd7;

   class car_door_scoreboard;
      cfg_type                 cfg;
      logic [POS_WIDTH-1:0]    pos_steps;
      logic [FLOOR_WIDTH-1:0]  at_floor;
      logic [DOOR_WIDTH-1:0]   door;
      logic [DPOS_WIDTH-1:0]   door_open_amt;
      logic [HOLD_WIDTH-1:0]   hold_left;
      logic [REQ_WIDTH-1:0]    pending_calls;
      logic                    landed;
      logic                    halted;
      rsp_payload_type         outstanding[$];
      int                      errors;
      int                      items_noted;
      int                      results_checked;
      int                      landings;

      function new();
         cfg.steps_per_floor   = SPF_RESET;
         cfg.door_travel_ticks = TRAVEL_RESET;
         cfg.door_hold_ticks   = HOLD_RESET;
         at_floor      = FLOOR_WIDTH'(HOME_FLOOR_DEFAULT);
         pos_steps     = shaft_pos(at_floor);
         door          = DS_CLOSED;
         door_open_amt = '0;
         hold_left     = '0;
         pending_calls = '0;
         landed        = 1'b0;
         halted        = 1'b0;
         errors          = 0;
         items_noted     = 0;
         results_checked = 0;
         landings        = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            REG_STEPS_PER_FLOOR: cfg.steps_per_floor   = value[SPF_WIDTH-1:0];
            REG_DOOR_TRAVEL:     cfg.door_travel_ticks = value[DPOS_WIDTH-1:0];
            REG_DOOR_HOLD:       cfg.door_hold_ticks   = value[HOLD_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_WIDTH-1:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_STEPS_PER_FLOOR: return CSR_DATA_WIDTH'(cfg.steps_per_floor);
            REG_DOOR_TRAVEL:     return CSR_DATA_WIDTH'(cfg.door_travel_ticks);
            REG_DOOR_HOLD:       return CSR_DATA_WIDTH'(cfg.door_hold_ticks);
            default:             return '0;
         endcase
      endfunction

      function logic [POS_WIDTH-1:0] shaft_pos(logic [FLOOR_WIDTH-1:0] f);
         int unsigned steps;
         steps = int'(f) * int'(cfg.steps_per_floor);
         return steps[POS_WIDTH-1:0];
      endfunction

      function logic [FLOOR_WIDTH-1:0] next_stop();
         for (int i = 0; i < REQ_WIDTH; i++) begin
            if (pending_calls[i]) begin
               return FLOOR_WIDTH'(i);
            end
         end
         return at_floor;
      endfunction

      function logic is_level();
         return pos_steps == shaft_pos(at_floor);
      endfunction

      function void advance();
         logic [FLOOR_WIDTH-1:0] goal;
         logic [POS_WIDTH-1:0]   goal_pos;
         logic [DPOS_WIDTH:0]    wider;
         if (halted) begin
            return;
         end
         goal     = next_stop();
         goal_pos = shaft_pos(goal);
         // car only moves with the doors shut
         if (door == DS_CLOSED) begin
            if (pos_steps < goal_pos) begin
               pos_steps = pos_steps + 1'b1;
            end else if (pos_steps > goal_pos) begin
               pos_steps = pos_steps - 1'b1;
            end
            if (pos_steps == goal_pos) begin
               if (!landed) begin
                  at_floor            = goal;
                  pending_calls[goal] = 1'b0;
                  door                = DS_OPENING;
                  landed              = 1'b1;
                  landings++;
               end
            end else begin
               landed = 1'b0;
            end
         end
         // door phases fall through within one tick
         if (door == DS_OPENING) begin
            wider = {1'b0, door_open_amt} + 1'b1;
            if (wider >= {1'b0, cfg.door_travel_ticks}) begin
               door_open_amt = cfg.door_travel_ticks;
               door          = DS_OPEN;
               hold_left     = cfg.door_hold_ticks;
            end else begin
               door_open_amt = wider[DPOS_WIDTH-1:0];
            end
         end
         if (door == DS_OPEN) begin
            if (hold_left <= 1) begin
               hold_left = '0;
               door      = DS_CLOSING;
            end else begin
               hold_left = hold_left - 1'b1;
            end
         end
         if (door == DS_CLOSING) begin
            if (door_open_amt <= 1) begin
               door_open_amt = '0;
               door          = DS_CLOSED;
            end else begin
               door_open_amt = door_open_amt - 1'b1;
            end
         end
      endfunction

      function void call_floor(logic [FLOOR_WIDTH-1:0] f);
         if (int'(f) >= FLOORS_DEFAULT) begin
            return;
         end
         if (f == at_floor && is_level()) begin
            if (door == DS_CLOSED) begin
               door   = DS_OPENING;
               landed = 1'b1;
            end
            pending_calls[f] = 1'b0;
            return;
         end
         pending_calls[f] = 1'b1;
      endfunction

      function void press_open();
         logic [HOLD_WIDTH:0] sum;
         if (door == DS_OPEN) begin
            sum       = {1'b0, hold_left} + {1'b0, cfg.door_hold_ticks};
            hold_left = sum[HOLD_WIDTH] ? {HOLD_WIDTH{1'b1}} : sum[HOLD_WIDTH-1:0];
         end else if (door == DS_CLOSED && is_level()) begin
            door   = DS_OPENING;
            landed = 1'b1;
         end
      endfunction

      // accepted input transfer: update state, queue the resulting snapshot
      function void note(req_payload_type item);
         rsp_payload_type snap;
         case (item.op)
            OP_TICK:    advance();
            OP_REQUEST: call_floor(item.floor);
            OP_OPEN:    press_open();
            OP_CLOSE: begin
               if (door == DS_OPEN || door == DS_OPENING) begin
                  door = DS_CLOSING;
               end
            end
            OP_STOP:    halted = ~halted;
            default: ;
         endcase
         snap.current_floor = at_floor;
         snap.target_floor  = next_stop();
         snap.car_position  = pos_steps;
         snap.door_state    = door;
         snap.door_position = door_open_amt;
         snap.requests      = pending_calls;
         snap.stopped       = halted;
         outstanding.push_back(snap);
         items_noted++;
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check(rsp_payload_type got);
         rsp_payload_type want;
         if (outstanding.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
            return;
         end
         want = outstanding.pop_front();
         compare_field("current_floor", want.current_floor, got.current_floor);
         compare_field("target_floor",  want.target_floor,  got.target_floor);
         compare_field("car_position",  want.car_position,  got.car_position);
         compare_field("door_state",    want.door_state,    got.door_state);
         compare_field("door_position", want.door_position, got.door_position);
         compare_field("requests",      want.requests,      got.requests);
         compare_field("stopped",       want.stopped,       got.stopped);
         results_checked++;
      endfunction

      function int pending();
         return outstanding.size();
      endfunction
   endclass

endpackage

### test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import ecdc_pkg::*;
   import ecdc_tb_pkg::*;

   // Generous cycle budget: ~700 transfers at worst-case gaps on both sides
   // stay well inside it, with plenty of slack.
   localparam int CYCLE_LIMIT = 200000;
   // Two-stage pipe, so SETTLE_CYCLES of quiet is enough to call it idle
   localparam int SETTLE_CYCLES = 4;

   logic clock;
   logic reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   ecdc_stream_if #(.payload_type(req_payload_type)) req_if ();
   ecdc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   elevator_car_door_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   car_door_scoreboard model;

   int send_gap_max;    // per-transfer idle draw on the request side
   int take_gap_max;    // per-transfer stall draw on the result side
   int burst_cycles;    // one-shot long result stall, picked up by the receiver
   int csr_errors;
   int settings_loaded;
   int cycle_count;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, model.pending());
         $display("elevator_car_door_controller regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // CSR access. Setup phase, access phase, register takes the write at the
   // access-phase edge. Every write is read back.
   // ---------------------------------------------------------------------
   task automatic csr_check(input logic [1:0] idx);
      logic [CSR_DATA_WIDTH-1:0] want;
      want = model.reg_value(idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         csr_errors++;
         $display("%0t: register %0d readback, expected %0d, actual %0d",
                  $time, idx, want, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_check(idx);
   endtask

   task automatic load_settings(input int spf, input int travel, input int hold);
      csr_write(REG_STEPS_PER_FLOOR, spf);
      csr_write(REG_DOOR_TRAVEL, travel);
      csr_write(REG_DOOR_HOLD, hold);
      settings_loaded++;
   endtask

   // ---------------------------------------------------------------------
   // Request side. valid stays high across back-to-back transfers; it drops
   // when this item draws an idle gap, or when settle() drains the block.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [OP_WIDTH-1:0] op, input logic [FLOOR_WIDTH-1:0] fl);
      req_payload_type item;
      int              gap;
      item.op    = op;
      item.floor = fl;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      model.note(item);
   endtask

   // Drop valid and let the block drain before touching registers
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly ticks with a steady sprinkle of calls and buttons, so the car
   // actually travels and the doors run full cycles. While stopped, the stop
   // toggle is much likelier so the car does not stay frozen for long.
   task automatic run_random(input int count);
      logic [OP_WIDTH-1:0]    op;
      logic [FLOOR_WIDTH-1:0] fl;
      int                     roll;
      int                     counted;
      counted = 0;
      while (counted < count) begin
         roll = $urandom_range(0, 99);
         fl   = $urandom_range(0, 7);
         if (model.halted && roll < 40) begin
            op = OP_STOP;
         end else if (roll < 58) begin
            op = OP_TICK;
         end else if (roll < 78) begin
            op = OP_REQUEST;
         end else if (roll < 87) begin
            op = OP_OPEN;
         end else if (roll < 94) begin
            op = OP_CLOSE;
         end else if (roll < 96) begin
            op = OP_STOP;
         end else begin
            op = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
         end
         send_item(op, fl);
         if (op <= OP_STOP) begin
            counted++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: own process, draws a stall per transfer and checks every
   // result against the oldest prediction.
   // ---------------------------------------------------------------------
   initial begin : take_side
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, take_gap_max);
         if (burst_cycles > 0) begin
            stall        = burst_cycles;
            burst_cycles = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         model.check(rsp_if.payload);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_gap_max    = 3;
      take_gap_max    = 3;
      burst_cycles    = 0;
      csr_errors      = 0;
      settings_loaded = 0;
      cycle_count     = 0;
      model = new();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of all three registers
      csr_check(REG_STEPS_PER_FLOOR);
      csr_check(REG_DOOR_TRAVEL);
      csr_check(REG_DOOR_HOLD);

      // Directed walk with the reset floor spacing and short doors. Car sits
      // level at the home floor (position 46) with doors closed.
      load_settings(23, 2, 3);
      send_item(OP_REQUEST, 3'd2);   // call for the floor the car is level at
      send_item(OP_TICK, 3'd5);      // opening
      send_item(OP_TICK, 3'd0);      // fully open, hold loaded and counting
      send_item(OP_OPEN, 3'd0);      // open while open extends hold
      send_item(OP_CLOSE, 3'd0);     // close while open
      send_item(OP_OPEN, 3'd7);      // open while closing does nothing
      send_item(OP_TICK, 3'd0);
      send_item(OP_TICK, 3'd0);      // closed again
      send_item(OP_REQUEST, 3'd7);   // top floor
      send_item(OP_REQUEST, 3'd0);   // bottom floor wins the target
      send_item(OP_TICK, 3'd0);      // car leaves home level
      send_item(OP_REQUEST, 3'd2);   // current floor while not level: queued
      send_item(OP_OPEN, 3'd0);      // open while closed but between floors
      send_item(OP_STOP, 3'd0);
      send_item(OP_TICK, 3'd0);      // frozen
      send_item(OP_REQUEST, 3'd5);   // calls still taken while stopped
      send_item(OP_STOP, 3'd7);
      send_item(OP_SPARE_FIRST, 3'd7);
      send_item(OP_SPARE_MID, 3'd0);
      send_item(OP_SPARE_LAST, 3'd7);
      repeat (44) send_item(OP_TICK, 3'd0);   // travel down the shaft
      send_item(OP_TICK, 3'd0);      // lands at the bottom, doors opening
      send_item(OP_CLOSE, 3'd0);     // close while opening
      send_item(OP_TICK, 3'd0);
      settle();

      // Random phases: smallest settings, the top extremes, hold saturation,
      // then a few mid-size mixes. Gap sizes vary per phase, including
      // stretches with no idling on either side.
      send_gap_max = 7;
      take_gap_max = 7;
      load_settings(1, 1, 1);
      run_random(100);
      settle();

      send_gap_max = 0;
      take_gap_max = 0;
      load_settings(4095, 1023, 65535);
      run_random(30);
      settle();

      // one-tick doors with the longest hold: open presses saturate the timer
      send_gap_max = 7;
      take_gap_max = 0;
      load_settings(1, 1, 65535);
      run_random(80);
      settle();

      // back-pressure: result side holds off while requests keep coming
      send_gap_max = 0;
      take_gap_max = 2;
      load_settings(2, 3, 5);
      burst_cycles = 60;
      run_random(150);
      settle();

      send_gap_max = 5;
      take_gap_max = 5;
      load_settings(3, 2, 4);
      run_random(150);
      settle();

      send_gap_max = 0;
      take_gap_max = 7;
      load_settings(1, 4, 8);
      run_random(100);
      settle();

      repeat (10) @(posedge clock);

      $display("covered %0d request transfers over %0d register settings",
               model.items_noted, settings_loaded);
      $display("checked %0d results, %0d floor arrivals", model.results_checked,
               model.landings);
      if (model.errors == 0 && csr_errors == 0 && model.pending() == 0) begin
         $display("elevator_car_door_controller regression: pass");
      end else begin
         $display("elevator_car_door_controller regression: fail");
      end
      $finish;
   end

endmodule
